/* rtl/core/smc_pkg.sv */
// Shared types, codes and constants for the sprite mask collision block.
package smc_pkg;

	localparam int DEF_MAX_SIDE = 64;
	localparam int ALPHA_SHIFT  = 6;
	localparam int SIDE_W       = 7;
	localparam int COORD_W      = 16;
	localparam int IDX_W        = 12;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	typedef enum logic [1:0] {
		CMD_LOAD_A = 2'd0,
		CMD_LOAD_B = 2'd1,
		CMD_CHECK  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A_LEFT = 3'd0,
		REG_A_TOP  = 3'd1,
		REG_A_COLS = 3'd2,
		REG_A_ROWS = 3'd3,
		REG_B_LEFT = 3'd4,
		REG_B_TOP  = 3'd5,
		REG_B_COLS = 3'd6,
		REG_B_ROWS = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_BASE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} scan_state_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] a_left;
		logic signed [COORD_W-1:0] a_top;
		logic        [SIDE_W-1:0]  a_cols;
		logic        [SIDE_W-1:0]  a_rows;
		logic signed [COORD_W-1:0] b_left;
		logic signed [COORD_W-1:0] b_top;
		logic        [SIDE_W-1:0]  b_cols;
		logic        [SIDE_W-1:0]  b_rows;
	} geom_t;

	typedef struct packed {
		logic                      collided;
		logic signed [COORD_W-1:0] hit_x;
		logic signed [COORD_W-1:0] hit_y;
	} result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} scan_status_t;

endpackage

/* rtl/core/smc_mask.sv */
// One-bit opacity mask memory, one write port and one registered read port.
module smc_mask import smc_pkg::*; #(
	parameter int DEPTH  = DEF_MAX_SIDE * DEF_MAX_SIDE,
	parameter int ADDR_W = $clog2(DEF_MAX_SIDE * DEF_MAX_SIDE)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic              wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic              rdata
);

	logic mask_q [DEPTH];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mask_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mask_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/smc_scan.sv */
// Overlap setup and row-major scan sequencer over the two mask memories.
module smc_scan import smc_pkg::*; #(
	parameter int MAX_SIDE = DEF_MAX_SIDE,
	parameter int ADDR_W   = $clog2(DEF_MAX_SIDE * DEF_MAX_SIDE)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              res_free,
	input  geom_t             geom,
	output logic [ADDR_W-1:0] raddr_a,
	output logic [ADDR_W-1:0] raddr_b,
	input  logic              rdata_a,
	input  logic              rdata_b,
	output scan_status_t      status,
	output result_t           result
);

	localparam logic [SIDE_W-1:0] SIDE_CAP =
		(MAX_SIDE > 127) ? SIDE_W'(127) : SIDE_W'(MAX_SIDE);

	scan_state_t state_q, state_d;

	// overlap geometry, edges and sums in 18-bit signed so edges past 16 bits compare right
	logic [SIDE_W-1:0]  aw, ah, bw, bh;
	logic signed [17:0] ax_e, ay_e, bx_e, by_e;
	logic signed [17:0] aw_e, ah_e, bw_e, bh_e;
	logic signed [17:0] ax2, ay2, bx2, by2;
	logic signed [17:0] x1_e, y1_e, x2_e, y2_e;
	logic signed [17:0] ca0_e, cb0_e, ra0_e, rb0_e, wl_e, hl_e;
	logic               empty;

	logic                      empty_q;
	logic        [SIDE_W-1:0]  aw_q, bw_q;
	logic        [SIDE_W-1:0]  ca0_q, cb0_q, ra0_q, rb0_q;
	logic        [SIDE_W-1:0]  wlast_q, hlast_q;
	logic signed [COORD_W-1:0] x1_q, y1_q;

	logic        [SIDE_W-1:0]  col_q, row_q;
	logic        [ADDR_W-1:0]  ptr_a_q, ptr_b_q, row_a_q, row_b_q;
	logic        [ADDR_W-1:0]  next_row_a, next_row_b;
	logic        [2*SIDE_W-1:0] base_a, base_b;
	logic signed [COORD_W-1:0] scr_x_q, scr_y_q;

	logic                      valid_s1;
	logic signed [COORD_W-1:0] x_s1, y_s1;
	logic                      hit_now;
	logic                      row_end, last_pix;
	result_t                   res_q;

	always_comb begin
		aw = (geom.a_cols > SIDE_CAP) ? SIDE_CAP : geom.a_cols;
		ah = (geom.a_rows > SIDE_CAP) ? SIDE_CAP : geom.a_rows;
		bw = (geom.b_cols > SIDE_CAP) ? SIDE_CAP : geom.b_cols;
		bh = (geom.b_rows > SIDE_CAP) ? SIDE_CAP : geom.b_rows;
		ax_e = 18'(geom.a_left);
		ay_e = 18'(geom.a_top);
		bx_e = 18'(geom.b_left);
		by_e = 18'(geom.b_top);
		aw_e = $signed(18'(aw));
		ah_e = $signed(18'(ah));
		bw_e = $signed(18'(bw));
		bh_e = $signed(18'(bh));
		ax2 = ax_e + aw_e - 18'sd1;
		ay2 = ay_e + ah_e - 18'sd1;
		bx2 = bx_e + bw_e - 18'sd1;
		by2 = by_e + bh_e - 18'sd1;
		x1_e = (ax_e > bx_e) ? ax_e : bx_e;
		y1_e = (ay_e > by_e) ? ay_e : by_e;
		x2_e = (ax2 < bx2) ? ax2 : bx2;
		y2_e = (ay2 < by2) ? ay2 : by2;
		empty = (x2_e < x1_e) || (y2_e < y1_e);
		ca0_e = x1_e - ax_e;
		cb0_e = x1_e - bx_e;
		ra0_e = y1_e - ay_e;
		rb0_e = y1_e - by_e;
		wl_e  = x2_e - x1_e;
		hl_e  = y2_e - y1_e;
	end

	assign base_a     = aw_q * ra0_q;
	assign base_b     = bw_q * rb0_q;
	assign next_row_a = row_a_q + ADDR_W'(aw_q);
	assign next_row_b = row_b_q + ADDR_W'(bw_q);
	assign row_end    = (col_q == wlast_q);
	assign last_pix   = row_end && (row_q == hlast_q);
	assign hit_now    = valid_s1 && rdata_a && rdata_b;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (start) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_BASE;
			ST_BASE:  state_d = empty_q ? ST_DONE : ST_SCAN;
			ST_SCAN: begin
				if (hit_now) begin
					state_d = ST_DONE;
				end else if (last_pix) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE:  if (res_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		status.busy = (state_q != ST_IDLE);
		status.done = (state_q == ST_DONE);
		raddr_a     = ptr_a_q;
		raddr_b     = ptr_b_q;
		result      = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == ST_SCAN) && !hit_now;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			empty_q <= empty;
			aw_q    <= aw;
			bw_q    <= bw;
			ca0_q   <= ca0_e[SIDE_W-1:0];
			cb0_q   <= cb0_e[SIDE_W-1:0];
			ra0_q   <= ra0_e[SIDE_W-1:0];
			rb0_q   <= rb0_e[SIDE_W-1:0];
			wlast_q <= wl_e[SIDE_W-1:0];
			hlast_q <= hl_e[SIDE_W-1:0];
			x1_q    <= x1_e[COORD_W-1:0];
			y1_q    <= y1_e[COORD_W-1:0];
		end

		if (state_q == ST_BASE) begin
			row_a_q <= ADDR_W'(base_a) + ADDR_W'(ca0_q);
			ptr_a_q <= ADDR_W'(base_a) + ADDR_W'(ca0_q);
			row_b_q <= ADDR_W'(base_b) + ADDR_W'(cb0_q);
			ptr_b_q <= ADDR_W'(base_b) + ADDR_W'(cb0_q);
			col_q   <= '0;
			row_q   <= '0;
			scr_x_q <= x1_q;
			scr_y_q <= y1_q;
			res_q   <= '0;
		end else if (state_q == ST_SCAN) begin
			if (row_end) begin
				col_q   <= '0;
				row_q   <= row_q + 1'b1;
				row_a_q <= next_row_a;
				row_b_q <= next_row_b;
				ptr_a_q <= next_row_a;
				ptr_b_q <= next_row_b;
				scr_x_q <= x1_q;
				scr_y_q <= scr_y_q + COORD_W'(1);
			end else begin
				col_q   <= col_q + 1'b1;
				ptr_a_q <= ptr_a_q + 1'b1;
				ptr_b_q <= ptr_b_q + 1'b1;
				scr_x_q <= scr_x_q + COORD_W'(1);
			end
		end

		x_s1 <= scr_x_q;
		y_s1 <= scr_y_q;

		// first hit wins; the scan stops on the same edge
		if (hit_now) begin
			res_q.collided <= 1'b1;
			res_q.hit_x    <= x_s1;
			res_q.hit_y    <= y_s1;
		end
	end

endmodule

/* rtl/core/sprite_mask_collision.sv */
// Sprite pixel-mask collision: loads write one mask bit each.
// A check of the scanned pixel pairs (up to 64 x 64) runs the setup states SETUP and BASE,
// then the row-major scan of the pairs, the registered mask read and the output register;
// it ends early at the first hit, and goes from BASE to DONE when the overlap is empty.
// Requests stall until the result is in the output register; from then on the next is taken.
// Reset clears the geometry registers, the valid flags and control; mask contents are undefined until loaded.
module sprite_mask_collision import smc_pkg::*; #(
	parameter int MAX_SIDE = DEF_MAX_SIDE
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_stall,
	input  logic [1:0]                command,
	input  logic [IDX_W-1:0]          pixel_index,
	input  logic [7:0]                pixel_value,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic                      collided,
	output logic signed [COORD_W-1:0] hit_x,
	output logic signed [COORD_W-1:0] hit_y,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W = $clog2(DEPTH);

	geom_t        geom_q;
	result_t      res_q, scan_res;
	scan_status_t scan_st;
	logic         res_valid_q;
	logic         res_free;
	logic         cmd_acc;
	logic         idx_ok;
	logic         opaque;
	logic         we_a, we_b;
	logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
	logic         rdata_a, rdata_b;
	cmd_t         cmd;

	assign cmd       = cmd_t'(command);
	assign cmd_stall = scan_st.busy;
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;
	assign idx_ok    = 32'(pixel_index) < DEPTH;
	assign opaque    = |pixel_value[7:ALPHA_SHIFT];
	assign waddr     = ADDR_W'(pixel_index);
	assign we_a      = cmd_acc && idx_ok && (cmd == CMD_LOAD_A);
	assign we_b      = cmd_acc && idx_ok && (cmd == CMD_LOAD_B);
	assign res_free  = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_A_LEFT: geom_q.a_left <= $signed(cfg_data);
				REG_A_TOP:  geom_q.a_top  <= $signed(cfg_data);
				REG_A_COLS: geom_q.a_cols <= cfg_data[SIDE_W-1:0];
				REG_A_ROWS: geom_q.a_rows <= cfg_data[SIDE_W-1:0];
				REG_B_LEFT: geom_q.b_left <= $signed(cfg_data);
				REG_B_TOP:  geom_q.b_top  <= $signed(cfg_data);
				REG_B_COLS: geom_q.b_cols <= cfg_data[SIDE_W-1:0];
				REG_B_ROWS: geom_q.b_rows <= cfg_data[SIDE_W-1:0];
				default:    geom_q <= geom_q;
			endcase
		end
	end

	smc_mask #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mask_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (opaque),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	smc_mask #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mask_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (opaque),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	smc_scan #(.MAX_SIDE(MAX_SIDE), .ADDR_W(ADDR_W)) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd_acc && (cmd == CMD_CHECK)),
		.res_free (res_free),
		.geom     (geom_q),
		.raddr_a  (raddr_a),
		.raddr_b  (raddr_b),
		.rdata_a  (rdata_a),
		.rdata_b  (rdata_b),
		.status   (scan_st),
		.result   (scan_res)
	);

	// result register: the next request can be taken while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (scan_st.done && res_free) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_st.done && res_free) begin
			res_q <= scan_res;
		end
	end

	assign res_valid = res_valid_q;
	assign collided  = res_q.collided;
	assign hit_x     = res_q.hit_x;
	assign hit_y     = res_q.hit_y;

`ifndef SYNTHESIS
	a_no_load_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_st.busy |-> !(we_a || we_b))
		else $error("mask written while a check is running");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_st.done && !res_free) |=> scan_st.done)
		else $error("check result dropped while output slot full");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !collided) |-> (hit_x == '0 && hit_y == '0))
		else $error("miss reported with non-zero hit point");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && cmd == CMD_CHECK) |=> (scan_st.busy && !scan_st.done))
		else $error("check request did not start the scan");
`endif

endmodule

/* sim/smc_scoreboard.sv */
// Mask and geometry predictor for the sprite collision testbench, with the queue of awaited results.
package smc_tb_pkg;
	import smc_pkg::*;

	localparam int SIDE  = DEF_MAX_SIDE;
	localparam int DEPTH = SIDE * SIDE;

	typedef struct {
		cmd_t        sprite;
		int unsigned index;
	} mask_slot_t;

	class collision_model;
		geom_t   geom;
		bit      opaque_a [DEPTH];
		bit      opaque_b [DEPTH];
		bit      loaded_a [DEPTH];
		bit      loaded_b [DEPTH];
		result_t awaited [$];
		int      mismatches;
		int      hits;
		// screen geometry of the current setting, sides already saturated
		int      ax, ay, aw, ah, bx, by, bw, bh;
		int      x1, y1, x2, y2;

		function new();
			geom = '0;
			mismatches = 0;
			hits = 0;
			frame();
		endfunction

		function int side(logic [SIDE_W-1:0] s);
			return (s > SIDE) ? SIDE : int'(s);
		endfunction

		function void frame();
			ax = $signed(geom.a_left);
			ay = $signed(geom.a_top);
			bx = $signed(geom.b_left);
			by = $signed(geom.b_top);
			aw = side(geom.a_cols);
			ah = side(geom.a_rows);
			bw = side(geom.b_cols);
			bh = side(geom.b_rows);
			x1 = (ax > bx) ? ax : bx;
			y1 = (ay > by) ? ay : by;
			x2 = (ax + aw < bx + bw) ? ax + aw - 1 : bx + bw - 1;
			y2 = (ay + ah < by + bh) ? ay + ah - 1 : by + bh - 1;
		endfunction

		function void write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
			case (r)
				REG_A_LEFT: geom.a_left = d;
				REG_A_TOP:  geom.a_top  = d;
				REG_A_COLS: geom.a_cols = d[SIDE_W-1:0];
				REG_A_ROWS: geom.a_rows = d[SIDE_W-1:0];
				REG_B_LEFT: geom.b_left = d;
				REG_B_TOP:  geom.b_top  = d;
				REG_B_COLS: geom.b_cols = d[SIDE_W-1:0];
				REG_B_ROWS: geom.b_rows = d[SIDE_W-1:0];
				default: ;
			endcase
			frame();
		endfunction

		// Row-major walk of the overlap. When probing, stop at the first pair with a
		// mask bit never loaded, and look one pair past the hit (read-ahead).
		function void scan(input bit probe, output result_t res, output bit holed,
				output int hole_y);
			int ia, ib;
			bit done, found;
			res = '0;
			holed = 0;
			hole_y = 0;
			done = 0;
			found = 0;
			for (int y = y1; y <= y2 && !done; y++) begin
				for (int x = x1; x <= x2 && !done; x++) begin
					ia = aw * (y - ay) + (x - ax);
					ib = bw * (y - by) + (x - bx);
					if (probe && !(loaded_a[ia] && loaded_b[ib])) begin
						holed = 1;
						hole_y = y;
						done = 1;
					end else if (found) begin
						done = 1;
					end else if (opaque_a[ia] && opaque_b[ib]) begin
						found = 1;
						res.collided = 1'b1;
						res.hit_x = COORD_W'(x);
						res.hit_y = COORD_W'(y);
						done = !probe;
					end
				end
			end
		endfunction

		// unloaded entries of the first overlap row with a hole that a check would read blind
		function void gaps(ref mask_slot_t slots[$]);
			result_t res;
			bit holed;
			int hy, ia, ib;
			slots.delete();
			scan(1'b1, res, holed, hy);
			if (holed) begin
				for (int x = x1; x <= x2; x++) begin
					ia = aw * (hy - ay) + (x - ax);
					ib = bw * (hy - by) + (x - bx);
					if (!loaded_a[ia])
						slots.push_back('{CMD_LOAD_A, ia});
					if (!loaded_b[ib])
						slots.push_back('{CMD_LOAD_B, ib});
				end
			end
		endfunction

		function void take_request(cmd_t c, logic [IDX_W-1:0] idx, logic [7:0] value);
			result_t res;
			bit holed, opaque;
			int hy;
			opaque = (value >> ALPHA_SHIFT) != 0;
			case (c)
				CMD_LOAD_A: if (idx < DEPTH) begin
					opaque_a[idx] = opaque;
					loaded_a[idx] = 1'b1;
				end
				CMD_LOAD_B: if (idx < DEPTH) begin
					opaque_b[idx] = opaque;
					loaded_b[idx] = 1'b1;
				end
				CMD_CHECK: begin
					scan(1'b0, res, holed, hy);
					if (res.collided)
						hits++;
					awaited.push_back(res);
				end
				default: ;
			endcase
		endfunction

		function void compare_result(logic col, logic signed [COORD_W-1:0] hx,
				logic signed [COORD_W-1:0] hy);
			result_t want;
			if (awaited.size() == 0) begin
				$error("result with no check outstanding: collided %0d hit_x %0d hit_y %0d",
					col, hx, hy);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			if (col !== want.collided) begin
				$error("collided: expected %0d, got %0d", want.collided, col);
				mismatches++;
			end
			if (hx !== want.hit_x) begin
				$error("hit_x: expected %0d, got %0d", want.hit_x, hx);
				mismatches++;
			end
			if (hy !== want.hit_y) begin
				$error("hit_y: expected %0d, got %0d", want.hit_y, hy);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction
	endclass

endpackage

/* sim/sprite_mask_collision_tb.sv */
// Testbench for the sprite mask collision block: directed geometries, then random phases.
module sprite_mask_collision_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import smc_pkg::*;
	import smc_tb_pkg::*;

	localparam int QUIET_LIMIT  = 20000;
	localparam int SETTLE       = 16;
	localparam int LONG_HOLD    = 300;
	localparam int TOTAL_ITEMS  = 140;
	localparam int PAD_W        = CFG_DATA_W - SIDE_W;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cmd_valid = 1'b0;
	logic                      cmd_stall;
	logic [1:0]                command = '0;
	logic [IDX_W-1:0]          pixel_index = '0;
	logic [7:0]                pixel_value = '0;
	logic                      res_valid;
	logic                      res_stall = 1'b0;
	logic                      collided;
	logic signed [COORD_W-1:0] hit_x;
	logic signed [COORD_W-1:0] hit_y;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;

	collision_model sprites = new();
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;
	int dens_a = 50, dens_b = 50;
	int n_loads = 0, n_checks = 0, n_nops = 0, n_cfg = 0;

	sprite_mask_collision dut (.*);

	always #5 clk = ~clk;

	function automatic geom_t rect(input int al, input int at, input int ac, input int ar,
			input int bl, input int bt, input int bc, input int br);
		geom_t g;
		g.a_left = COORD_W'(al);
		g.a_top  = COORD_W'(at);
		g.a_cols = SIDE_W'(ac);
		g.a_rows = SIDE_W'(ar);
		g.b_left = COORD_W'(bl);
		g.b_top  = COORD_W'(bt);
		g.b_cols = SIDE_W'(bc);
		g.b_rows = SIDE_W'(br);
		return g;
	endfunction

	// mostly small sprites, now and then empty, large or oversized
	function automatic int pick_side();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 0;
		if (r == 1)
			return $urandom_range(65, 127);
		if (r < 4)
			return $urandom_range(9, 64);
		return $urandom_range(1, 8);
	endfunction

	function automatic geom_t random_rect();
		geom_t g;
		g.a_left = COORD_W'($urandom);
		g.a_top  = COORD_W'($urandom);
		g.a_cols = SIDE_W'(pick_side());
		g.a_rows = SIDE_W'(pick_side());
		g.b_cols = SIDE_W'(pick_side());
		g.b_rows = SIDE_W'(pick_side());
		if ($urandom_range(0, 4) == 0) begin
			g.b_left = COORD_W'($urandom);
			g.b_top  = COORD_W'($urandom);
		end else begin
			g.b_left = g.a_left + COORD_W'($urandom_range(0, 20) - 10);
			g.b_top  = g.a_top + COORD_W'($urandom_range(0, 20) - 10);
		end
		return g;
	endfunction

	// pixel byte drawn with the opacity density of the sprite
	function automatic logic [7:0] shade(cmd_t s);
		int d;
		d = (s == CMD_LOAD_A) ? dens_a : dens_b;
		if ($urandom_range(1, 100) <= d)
			return 8'($urandom_range(64, 255));
		return 8'($urandom_range(0, 63));
	endfunction

	task automatic send(cmd_t c, logic [IDX_W-1:0] idx, logic [7:0] value);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid   <= 1'b1;
		command     <= c;
		pixel_index <= idx;
		pixel_value <= value;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		sprites.take_request(c, idx, value);
		case (c)
			CMD_LOAD_A, CMD_LOAD_B: n_loads++;
			CMD_CHECK: n_checks++;
			default: n_nops++;
		endcase
	endtask

	// load every mask bit the scan would otherwise read unwritten, then request the check
	task automatic run_check();
		mask_slot_t slots[$];
		sprites.gaps(slots);
		while (slots.size() != 0) begin
			foreach (slots[i])
				send(slots[i].sprite, IDX_W'(slots[i].index), shade(slots[i].sprite));
			sprites.gaps(slots);
		end
		send(CMD_CHECK, IDX_W'($urandom), 8'($urandom));
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (sprites.outstanding() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(geom_t g);
		logic [CFG_DATA_W-1:0] word [8];
		cfg_reg_t r;
		word[REG_A_LEFT] = g.a_left;
		word[REG_A_TOP]  = g.a_top;
		word[REG_A_COLS] = {PAD_W'($urandom), g.a_cols};
		word[REG_A_ROWS] = {PAD_W'($urandom), g.a_rows};
		word[REG_B_LEFT] = g.b_left;
		word[REG_B_TOP]  = g.b_top;
		word[REG_B_COLS] = {PAD_W'($urandom), g.b_cols};
		word[REG_B_ROWS] = {PAD_W'($urandom), g.b_rows};
		r = r.first();
		do begin
			cfg_valid <= 1'b1;
			cfg_index <= r;
			cfg_data  <= word[r];
			do @(posedge clk); while (cfg_ready !== 1'b1);
			sprites.write_reg(r, word[r]);
			n_cfg++;
			r = r.next();
		end while (r != r.first());
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0)
			sprites.compare_result(collided, hit_x, hit_y);
	end

	initial begin : result_side
		int n;
		wait (arst_n === 1'b1);
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 7);
			if (hold_req) begin
				hold_req = 1'b0;
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (n > 0) begin
				// hold off once a result is showing
				res_stall <= 1'b1;
				do @(posedge clk); while (res_valid !== 1'b1);
				repeat (n - 1) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (res_valid !== 1'b1);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && cmd_stall === 1'b0) || (res_valid === 1'b1 && !res_stall) ||
					(cfg_valid && cfg_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		int phase, r, cells;
		cmd_t s;
		phase = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: both sprites are empty
		run_check();
		send(CMD_NOP, '1, '1);
		send(CMD_LOAD_A, IDX_W'(0), 8'h00);
		send(CMD_LOAD_A, IDX_W'(1), 8'h3f);
		send(CMD_LOAD_A, IDX_W'(4095), 8'h80);
		send(CMD_LOAD_B, IDX_W'(0), 8'h40);
		send(CMD_LOAD_B, IDX_W'(1), 8'hc0);
		send(CMD_LOAD_B, IDX_W'(4095), 8'hff);
		run_check();
		drain();

		// oversized sides saturate, strides too; the corners meet on 2 x 2 pixels.
		// A opaque, B clear: only the last pixel collides once B's bit there is set
		dens_a = 100;
		dens_b = 0;
		configure(rect(-40, -20, 127, 65, 22, 42, 100, 64));
		send(CMD_LOAD_B, IDX_W'(0), 8'h3f);
		send(CMD_LOAD_B, IDX_W'(1), 8'h00);
		run_check();
		send(CMD_LOAD_B, IDX_W'(65), 8'hc0);
		run_check();
		drain();

		// first hit lies past the top of the coordinate range and wraps
		configure(rect(32767, 32767, 64, 64, 32766, 32766, 4, 4));
		send(CMD_LOAD_B, IDX_W'(10), 8'hff);
		run_check();
		drain();

		configure(rect(0, 0, 4, 4, 2, 1, 4, 4));
		run_check();
		drain();
		configure(rect(-32768, -32768, 8, 8, 100, 100, 8, 8));
		run_check();
		drain();
		configure(rect(5, 5, 0, 9, 5, 5, 9, 9));
		run_check();
		drain();
		configure(rect(3, 3, 9, 9, 3, 3, 6, 0));
		run_check();
		drain();

		while ((n_loads + n_checks + n_nops) < TOTAL_ITEMS || phase < 2) begin
			phase++;
			no_idle = ($urandom_range(0, 3) == 0);
			dens_a = $urandom_range(0, 100);
			dens_b = $urandom_range(0, 100);
			configure(random_rect());
			if (phase == 2) begin
				// results back up behind a long receiver hold-off
				hold_req = 1'b1;
				repeat (5) begin
					run_check();
				end
			end
			repeat ($urandom_range(3, 10)) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					send(CMD_NOP, IDX_W'($urandom), 8'($urandom));
				end else if (r < 60) begin
					s = $urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A;
					cells = (s == CMD_LOAD_A) ? sprites.aw * sprites.ah : sprites.bw * sprites.bh;
					if (cells == 0 || $urandom_range(0, 4) == 0)
						cells = DEPTH;
					send(s, IDX_W'($urandom_range(0, cells - 1)),
						$urandom_range(0, 9) < 7 ? shade(s) : 8'($urandom));
				end else begin
					run_check();
				end
			end
			drain();
		end

		repeat (64) @(posedge clk);
		$display("Covered %0d mask loads, %0d checks with %0d hits and %0d unused commands,",
			n_loads, n_checks, sprites.hits, n_nops);
		$display("over %0d register writes: empty, saturated, wrapping and random geometries.",
			n_cfg);
		if (sprites.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
